// File: sv/assert_macros.svh
// Assertion helpers clocked on clk and held off while arst_n is low.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`define ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

`define ASSERT_IMPLIES(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

`define ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/tec_pkg.sv
package tec_pkg;

	localparam int CNT_W   = 5;
	localparam int WING_W  = 3;
	localparam int CTR_W   = 4;
	localparam int POS_W   = 16;
	localparam int CFG_W   = 16;
	localparam int CIDX_W  = 3;
	localparam int OUT_W   = 8;

	localparam logic [CTR_W-1:0] FRONT_MIN     = 4'd2;
	localparam logic [CTR_W-1:0] NO_CENTER_MAX = 4'd1;

	localparam logic [CIDX_W-1:0] CFG_CIRCLE_MIN = 3'd0;
	localparam logic [CIDX_W-1:0] CFG_WING_MIN   = 3'd1;
	localparam logic [CIDX_W-1:0] CFG_TURN_MIN   = 3'd2;
	localparam logic [CIDX_W-1:0] CFG_PERSIST    = 3'd3;
	localparam logic [CIDX_W-1:0] CFG_CIRCLE_MS  = 3'd4;
	localparam logic [CIDX_W-1:0] CFG_DEAD_MS    = 3'd5;
	localparam logic [CIDX_W-1:0] CFG_CURVE_OFF  = 3'd6;

	typedef enum logic [2:0] {
		ST_NORMAL   = 3'd0,
		ST_CURVE    = 3'd1,
		ST_TURN_L   = 3'd2,
		ST_TURN_R   = 3'd3,
		ST_JUNCTION = 3'd4,
		ST_CIRCLE   = 3'd5,
		ST_LOST     = 3'd6,
		ST_DEAD_END = 3'd7
	} track_state_t;

	typedef enum logic [2:0] {
		JK_NONE    = 3'd0,
		JK_CROSS   = 3'd1,
		JK_T_BOTH  = 3'd2,
		JK_T_LEFT  = 3'd3,
		JK_T_RIGHT = 3'd4,
		JK_LEFT    = 3'd5,
		JK_RIGHT   = 3'd6
	} junc_kind_t;

endpackage

// File: sv/track_element_classifier.sv
// Channel   Direction  Handshake          Payload
// s         in         s_tvalid/s_tready  s_tdata: one sensor snapshot
// m         out        m_tvalid/m_tready  m_tdata: track state, junction kind, changed
// cfg       in         cfg_we             cfg_index, cfg_data
//
// One item per cycle sustained while m_tready is high. Each item passes the input
// register, then the classifier and state update into the result register, as
// the tracking state is updated.
// arst_n clears both stage valids, all tracking state and the registers to defaults.
// A stalled result holds the input register; s_tready stays high while the input
// register is empty, or the result register is empty or being taken.
`include "assert_macros.svh"

module track_element_classifier
	import tec_pkg::*;
#(
	parameter int TIME_WIDTH = 32,
	localparam int IN_BITS = 1 + CNT_W + WING_W + CTR_W + WING_W + POS_W + TIME_WIDTH,
	localparam int IN_W    = ((IN_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	// line_present, active_count[5], left_count[3], center_count[4], right_count[3],
	// position[16], now_ms[TIME_WIDTH], zero fill
	input  logic [IN_W-1:0]     s_tdata,
	output logic                m_tvalid,
	input  logic                m_tready,
	// track_state[3], junction_kind[3], state_changed, zero fill
	output logic [OUT_W-1:0]    m_tdata,
	input  logic                cfg_we,
	input  logic [CIDX_W-1:0]   cfg_index,
	input  logic [CFG_W-1:0]    cfg_data
);

	localparam int ACT_LO  = 1;
	localparam int LFT_LO  = ACT_LO + CNT_W;
	localparam int CTR_LO  = LFT_LO + WING_W;
	localparam int RGT_LO  = CTR_LO + CTR_W;
	localparam int POS_LO  = RGT_LO + WING_W;
	localparam int NOW_LO  = POS_LO + POS_W;

	logic [CNT_W-1:0]  circ_min_q;
	logic [WING_W-1:0] wing_min_q;
	logic [WING_W-1:0] turn_min_q;
	logic [7:0]        persist_q;
	logic [15:0]       circ_ms_q;
	logic [15:0]       dead_ms_q;
	logic [14:0]       curve_off_q;

	logic                   valid_s1;
	logic                   line_s1;
	logic [CNT_W-1:0]       active_s1;
	logic [WING_W-1:0]      left_s1;
	logic [CTR_W-1:0]       center_s1;
	logic [WING_W-1:0]      right_s1;
	logic signed [POS_W-1:0] pos_s1;
	logic [TIME_WIDTH-1:0]  now_s1;

	track_state_t          cur_q, cand_state_q;
	junc_kind_t            junc_q, cand_junc_q;
	logic [7:0]            repeat_q;
	logic                  wide_act_q, seen_q, lost_act_q;
	logic [TIME_WIDTH-1:0] wide_start_q, lost_start_q;

	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;

	logic                  adv;
	logic                  wide;
	logic                  seen_n, wide_act_n, lost_act_n;
	logic [TIME_WIDTH-1:0] wide_start_n, lost_start_n, wide_el, lost_el;
	track_state_t          cand, cur_n, cand_state_n;
	junc_kind_t            jk, cand_junc_n, junc_n;
	logic [7:0]            repeat_n;
	logic                  dead;
	logic signed [POS_W:0] pos_x, off_x;

	function automatic junc_kind_t junction_of(
		input logic [WING_W-1:0] l,
		input logic [CTR_W-1:0]  c,
		input logic [WING_W-1:0] r,
		input logic [WING_W-1:0] wmin
	);
		logic hl, hf, hr;
		hl = l >= wmin;
		hf = c >= FRONT_MIN;
		hr = r >= wmin;
		priority if (hl && hr && hf) return JK_CROSS;
		else if (hl && hr) return JK_T_BOTH;
		else if (hl && hf) return JK_T_LEFT;
		else if (hr && hf) return JK_T_RIGHT;
		else if (hl) return JK_LEFT;
		else if (hr) return JK_RIGHT;
		else return JK_NONE;
	endfunction

	assign adv      = valid_s1 && (!out_valid_q || m_tready);
	assign s_tready = !valid_s1 || adv;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			circ_min_q  <= 5'd10;
			wing_min_q  <= 3'd3;
			turn_min_q  <= 3'd3;
			persist_q   <= 8'd3;
			circ_ms_q   <= 16'd100;
			dead_ms_q   <= 16'd500;
			curve_off_q <= 15'd2000;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_CIRCLE_MIN: circ_min_q  <= cfg_data[CNT_W-1:0];
				CFG_WING_MIN:   wing_min_q  <= cfg_data[WING_W-1:0];
				CFG_TURN_MIN:   turn_min_q  <= cfg_data[WING_W-1:0];
				CFG_PERSIST:    persist_q   <= cfg_data[7:0];
				CFG_CIRCLE_MS:  circ_ms_q   <= cfg_data;
				CFG_DEAD_MS:    dead_ms_q   <= cfg_data;
				CFG_CURVE_OFF:  curve_off_q <= cfg_data[14:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			line_s1   <= s_tdata[0];
			active_s1 <= s_tdata[ACT_LO +: CNT_W];
			left_s1   <= s_tdata[LFT_LO +: WING_W];
			center_s1 <= s_tdata[CTR_LO +: CTR_W];
			right_s1  <= s_tdata[RGT_LO +: WING_W];
			pos_s1    <= s_tdata[POS_LO +: POS_W];
			now_s1    <= s_tdata[NOW_LO +: TIME_WIDTH];
		end
	end

	always_comb begin
		wide         = active_s1 >= circ_min_q;
		seen_n       = seen_q | line_s1;
		lost_act_n   = lost_act_q;
		lost_start_n = lost_start_q;
		if (line_s1) begin
			lost_act_n   = 1'b0;
			lost_start_n = '0;
		end

		wide_act_n   = wide_act_q;
		wide_start_n = wide_start_q;
		if (wide) begin
			if (!wide_act_q) begin
				wide_start_n = now_s1;
				wide_act_n   = 1'b1;
			end
		end else begin
			wide_act_n   = 1'b0;
			wide_start_n = '0;
		end

		jk          = junction_of(left_s1, center_s1, right_s1, wing_min_q);
		cand_junc_n = cand_junc_q;
		pos_x       = {pos_s1[POS_W-1], pos_s1};
		off_x       = {2'b00, curve_off_q};
		priority if (!line_s1) begin
			cand = ST_LOST;
		end else if (wide) begin
			cand = ST_CIRCLE;
		end else begin
			cand_junc_n = jk;
			priority if (jk != JK_NONE) begin
				cand = ST_JUNCTION;
			end else if (left_s1 >= turn_min_q && center_s1 <= NO_CENTER_MAX &&
					!(right_s1 >= turn_min_q)) begin
				cand = ST_TURN_L;
			end else if (right_s1 >= turn_min_q && center_s1 <= NO_CENTER_MAX &&
					!(left_s1 >= turn_min_q)) begin
				cand = ST_TURN_R;
			end else if (pos_x < -off_x || pos_x > off_x) begin
				cand = ST_CURVE;
			end else begin
				cand = ST_NORMAL;
			end
		end

		wide_el = now_s1 - wide_start_n;
		if (cand == ST_CIRCLE && (!wide_act_n || wide_el < TIME_WIDTH'(circ_ms_q))) begin
			cand = (cur_q == ST_CIRCLE) ? ST_CIRCLE : ST_NORMAL;
		end

		dead    = 1'b0;
		lost_el = '0;
		if (!line_s1 && seen_n) begin
			if (!lost_act_n) begin
				lost_start_n = now_s1;
				lost_act_n   = 1'b1;
			end
			lost_el = now_s1 - lost_start_n;
			dead    = (lost_el > TIME_WIDTH'(dead_ms_q)) && (cur_q == ST_LOST);
		end

		cur_n        = cur_q;
		junc_n       = junc_q;
		cand_state_n = cand_state_q;
		repeat_n     = repeat_q;
		if (dead) begin
			cur_n = ST_DEAD_END;
		end else begin
			if (cand == cand_state_q) begin
				if (repeat_q != 8'hFF) repeat_n = repeat_q + 8'd1;
			end else begin
				cand_state_n = cand;
				repeat_n     = 8'd1;
			end
			if (repeat_n >= persist_q || cand == ST_LOST) begin
				if (cand == ST_JUNCTION) junc_n = cand_junc_n;
				cur_n = cand;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cur_q        <= ST_NORMAL;
			junc_q       <= JK_NONE;
			cand_state_q <= ST_NORMAL;
			cand_junc_q  <= JK_NONE;
			repeat_q     <= '0;
			wide_act_q   <= 1'b0;
			wide_start_q <= '0;
			seen_q       <= 1'b0;
			lost_act_q   <= 1'b0;
			lost_start_q <= '0;
		end else if (adv) begin
			cur_q        <= cur_n;
			junc_q       <= junc_n;
			cand_state_q <= cand_state_n;
			cand_junc_q  <= cand_junc_n;
			repeat_q     <= repeat_n;
			wide_act_q   <= wide_act_n;
			wide_start_q <= wide_start_n;
			seen_q       <= seen_n;
			lost_act_q   <= lost_act_n;
			lost_start_q <= lost_start_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			out_data_q <= {1'b0, (cur_n != cur_q), junc_n, cur_n};
		end
	end

	`ASSERT_IMPLIES(a_dead_end_from_lost,
		cur_q == ST_DEAD_END && $past(cur_q) != ST_DEAD_END, $past(cur_q) == ST_LOST,
		"dead end entered from a state other than lost")
	`ASSERT_IMPLIES(a_state_moves_on_item, cur_q != $past(cur_q), $past(adv),
		"track state changed without an item")
	`ASSERT_NEXT(a_loss_taken_at_once, adv && !line_s1,
		cur_q == ST_LOST || cur_q == ST_DEAD_END,
		"item without line did not leave the block lost or dead end")
	`ASSERT_ALWAYS(a_wide_start_cleared, wide_act_q || wide_start_q == '0,
		"wide timer start kept while no wide line")

endmodule
